// File: hw/rtl/rsim_pkg.sv
// Shared types and constants for the ring slot index manager.
package rsim_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int SIZE_W    = 11;
  localparam int AMT_W     = 12;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_SLOTS);

  typedef enum logic [2:0] {
    CMD_NEXT     = 3'd0,
    CMD_ROLLBACK = 3'd1,
    CMD_INDEX    = 3'd2,
    CMD_RESET    = 3'd3,
    CMD_RESIZE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POS_RANGE = 2'd1,
    ST_SIZE_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [AMT_W-1:0]  amount;
    logic [SIZE_W-1:0] size_req;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
    logic [SIZE_W-1:0] filled;
    logic [SIZE_W-1:0] current_size;
  } res_t;

endpackage

// File: hw/rtl/ring_slot_index_manager_core.sv
// Top level of the ring slot index manager: input register, pointer unit, result register.
//
// The block keeps head and write pointers for a ring that overwrites its
// oldest slot when full. Commands arrive on the in_ stream, one per beat,
// and each produces exactly one result beat on the out_ stream carrying the
// slot, a status code, the fill and the ring size after the command.
// A beat taken into the input register is executed against the pointer state
// when it advances, which a stall can delay, and its result is then held in
// the output register and shown on out_. Throughput is one command per cycle
// while out_ is not stalled, limited by the single pointer update per clock.
// When the receiver stalls, the result waits in the output register, and
// one more command can still be taken into the input register; in_tready
// drops only while both are occupied.
// A synchronous reset (rst_n low) empties the ring, sets both pointers to
// zero, sets the ring size to the maximum and drops both valid flags.
module ring_slot_index_manager_core
  import rsim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // amount[11:0], size_req[22:12], zero pad
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // slot[9:0], filled[20:10], current_size[31:21]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic in_v_r;
  req_t req_r;
  logic out_v_r;
  res_t res_r;
  res_t res_nxt;
  logic advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.command  <= in_tuser;
      req_r.amount   <= in_tdata[11:0];
      req_r.size_req <= in_tdata[22:12];
    end
  end

  rsim_ptr_unit u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_r),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r.current_size, res_r.filled, res_r.slot};
  assign out_tuser  = res_r.status;

  a_fill_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_r.filled <= res_r.current_size))
    else $error("fill exceeds ring size");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_r.current_size != '0 && res_r.current_size <= MAX_SIZE))
    else $error("ring size out of range");

  a_range_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.status == ST_POS_RANGE) |-> (res_r.slot == '0))
    else $error("out-of-range position reported a nonzero slot");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are held");

endmodule

// File: hw/rtl/rsim_ptr_unit.sv
// Pointer state of the ring and the combinational command logic that updates it.
module rsim_ptr_unit
  import rsim_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  req_t req,
  output res_t res
);

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] wr_r, wr_nxt;
  logic              empty_r, empty_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  logic [SIZE_W-1:0]   fill_cur;
  logic [SIZE_W-1:0]   head_inc;
  logic [SIZE_W-1:0]   wr_inc;
  logic [SIZE_W-1:0]   back_tmp;
  logic [AMT_W:0]      pos;
  logic [AMT_W:0]      pos_wrap;
  logic [SIZE_W-1:0]   size_clamp;
  logic [SLOT_W-1:0]   slot;
  logic [1:0]          status;

  function automatic logic [SIZE_W-1:0] fill_of(
    input logic              empty,
    input logic [SLOT_W-1:0] head,
    input logic [SLOT_W-1:0] wr,
    input logic [SIZE_W-1:0] size
  );
    logic [SIZE_W-1:0] fill;
    if (empty) begin
      fill = '0;
    end else if (wr == head) begin
      fill = size;
    end else if (wr > head) begin
      fill = {1'b0, wr} - {1'b0, head};
    end else begin
      fill = {1'b0, wr} + size - {1'b0, head};
    end
    return fill;
  endfunction

  always_comb begin
    fill_cur   = fill_of(empty_r, head_r, wr_r, size_r);
    head_inc   = {1'b0, head_r} + SIZE_W'(1);
    wr_inc     = {1'b0, wr_r} + SIZE_W'(1);
    // Only reached when amount is below the fill, so it fits in SIZE_W bits.
    back_tmp   = {1'b0, wr_r} + ((AMT_W'(wr_r) < req.amount) ? size_r : '0)
                 - req.amount[SIZE_W-1:0];
    pos        = (AMT_W+1)'(head_r) + (AMT_W+1)'(req.amount);
    pos_wrap   = pos - (AMT_W+1)'(size_r);
    size_clamp = (req.size_req > MAX_SIZE) ? MAX_SIZE : req.size_req;

    head_nxt  = head_r;
    wr_nxt    = wr_r;
    empty_nxt = empty_r;
    size_nxt  = size_r;
    slot      = '0;
    status    = ST_OK;

    unique case (req.command)
      CMD_NEXT: begin
        if (empty_r) begin
          empty_nxt = 1'b0;
        end else if (wr_r == head_r) begin
          head_nxt = (head_inc >= size_r) ? '0 : head_inc[SLOT_W-1:0];
        end
        slot   = wr_r;
        wr_nxt = (wr_inc >= size_r) ? '0 : wr_inc[SLOT_W-1:0];
      end
      CMD_ROLLBACK: begin
        if (AMT_W'(fill_cur) <= req.amount) begin
          empty_nxt = 1'b1;
          wr_nxt    = head_r;
        end else begin
          wr_nxt = back_tmp[SLOT_W-1:0];
        end
      end
      CMD_INDEX: begin
        if (pos < (AMT_W+1)'(size_r)) begin
          slot = pos[SLOT_W-1:0];
        end else if (pos_wrap < (AMT_W+1)'(size_r)) begin
          slot = pos_wrap[SLOT_W-1:0];
        end else begin
          status = ST_POS_RANGE;
        end
      end
      CMD_RESET: begin
        head_nxt  = '0;
        wr_nxt    = '0;
        empty_nxt = 1'b1;
      end
      CMD_RESIZE: begin
        if (req.size_req == '0) begin
          status = ST_SIZE_ZERO;
        end else begin
          size_nxt = size_clamp;
          head_nxt = '0;
          if (fill_cur == '0) begin
            wr_nxt    = '0;
            empty_nxt = 1'b1;
          end else begin
            wr_nxt = (fill_cur >= size_clamp) ? '0 : fill_cur[SLOT_W-1:0];
          end
        end
      end
      default: begin
        // Undefined commands leave the state alone.
      end
    endcase

    res.slot         = slot;
    res.status       = status;
    res.filled       = fill_of(empty_nxt, head_nxt, wr_nxt, size_nxt);
    res.current_size = size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      wr_r    <= '0;
      empty_r <= 1'b1;
      size_r  <= MAX_SIZE;
    end else if (advance) begin
      head_r  <= head_nxt;
      wr_r    <= wr_nxt;
      empty_r <= empty_nxt;
      size_r  <= size_nxt;
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench for ring_slot_index_manager_core: directed and random commands checked against a predictor.
module tb;
  import rsim_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 23;
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  ring_slot_index_manager_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predicted pointer state of the ring.
  int unsigned ring_head;
  int unsigned ring_wr;
  bit          ring_is_empty;
  int unsigned ring_size;

  res_t expected_results[$];
  int   mismatch_count;
  int   result_count;
  int   cycle_count;
  int   hold_left;
  bit   steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned ring_fill();
    if (ring_is_empty) return 0;
    if (ring_wr == ring_head) return ring_size;
    if (ring_wr > ring_head) return ring_wr - ring_head;
    return ring_wr + ring_size - ring_head;
  endfunction

  function automatic void empty_ring();
    ring_head     = 0;
    ring_wr       = 0;
    ring_is_empty = 1'b1;
  endfunction

  function automatic res_t predict_ring_result(logic [2:0] cmd, logic [11:0] amount,
                                               logic [10:0] size_req);
    res_t        r;
    int unsigned pos;
    int unsigned req;
    int unsigned f;
    r.slot   = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_NEXT: begin
        if (ring_is_empty) begin
          ring_is_empty = 1'b0;
        end else if (ring_wr == ring_head) begin
          // Full ring: the oldest slot is overwritten.
          ring_head = (ring_head + 1 >= ring_size) ? 0 : ring_head + 1;
        end
        r.slot  = ring_wr[SLOT_W-1:0];
        ring_wr = (ring_wr + 1 >= ring_size) ? 0 : ring_wr + 1;
      end
      CMD_ROLLBACK: begin
        if (ring_fill() <= amount) begin
          ring_is_empty = 1'b1;
          ring_wr       = ring_head;
        end else begin
          if (ring_wr < amount) ring_wr += ring_size;
          ring_wr -= amount;
        end
      end
      CMD_INDEX: begin
        pos = ring_head + amount;
        if (pos >= ring_size) begin
          pos -= ring_size;
          if (pos >= ring_size) begin
            r.status = ST_POS_RANGE;
            pos      = 0;
          end
        end
        r.slot = pos[SLOT_W-1:0];
      end
      CMD_RESET: empty_ring();
      CMD_RESIZE: begin
        if (size_req == 0) begin
          r.status = ST_SIZE_ZERO;
        end else begin
          req = (size_req > MAX_SLOTS) ? MAX_SLOTS : size_req;
          f   = ring_fill();
          ring_size = req;
          if (f == 0) begin
            empty_ring();
          end else begin
            ring_head = 0;
            ring_wr   = (f >= req) ? 0 : f;
          end
        end
      end
      default: ;
    endcase
    r.filled       = SIZE_W'(ring_fill());
    r.current_size = SIZE_W'(ring_size);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d, result %0d: %s", cycle_count, result_count, msg);
    mismatch_count++;
  endtask

  // Result checker: every accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, data %h status %0d",
                                  out_tdata, out_tuser));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[9:0] !== want.slot)
          report_mismatch($sformatf("slot got %0d expected %0d", out_tdata[9:0], want.slot));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", out_tuser, want.status));
        if (out_tdata[20:10] !== want.filled)
          report_mismatch($sformatf("filled got %0d expected %0d", out_tdata[20:10],
                                    want.filled));
        if (out_tdata[31:21] !== want.current_size)
          report_mismatch($sformatf("size got %0d expected %0d", out_tdata[31:21],
                                    want.current_size));
      end
      result_count++;
    end
  end

  // Receiver: random stalls, a steady mode, and a long hold-off counted here.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat was taken.
  task automatic send_cmd(logic [2:0] cmd, logic [11:0] amount, logic [10:0] size_req);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, size_req, amount};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_ring_result(cmd, amount, size_req));
    @(negedge clk);
  endtask

  // Random command shaped by the predicted state, so that wraps and overwrites happen often.
  task automatic send_random_cmd();
    int unsigned pick;
    int unsigned amt;
    int unsigned ns;
    pick = $urandom_range(99);
    amt  = 0;
    ns   = 0;
    if (pick < 40) begin
      send_cmd(CMD_NEXT, 12'($urandom_range(4095)), 11'($urandom_range(1024)));
    end else if (pick < 55) begin
      amt = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(ring_fill() + 2);
      send_cmd(CMD_ROLLBACK, 12'(amt), 11'($urandom_range(1024)));
    end else if (pick < 78) begin
      amt = ($urandom_range(4) == 0) ? $urandom_range(4095)
                                     : $urandom_range(2 * ring_size + 1);
      send_cmd(CMD_INDEX, 12'(amt), 11'($urandom_range(1024)));
    end else if (pick < 83) begin
      send_cmd(CMD_RESET, 12'($urandom_range(4095)), 11'($urandom_range(1024)));
    end else begin
      case ($urandom_range(9))
        0:       ns = 0;
        1:       ns = MAX_SLOTS;
        2, 3:    ns = $urandom_range(1, 1024);
        default: ns = $urandom_range(1, 12);
      endcase
      send_cmd(CMD_RESIZE, 12'($urandom_range(4095)), 11'(ns));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_NEXT, 12'd0, 11'd0);
    send_cmd(CMD_INDEX, 12'd0, 11'd0);
    send_cmd(CMD_INDEX, 12'd4095, 11'd2047);
    send_cmd(CMD_INDEX, 12'd2047, 11'd0);
    send_cmd(CMD_INDEX, 12'd2048, 11'd0);
    send_cmd(CMD_ROLLBACK, 12'd0, 11'd0);
    send_cmd(CMD_ROLLBACK, 12'd4095, 11'd0);
    send_cmd(CMD_RESIZE, 12'd0, 11'd0);
    // A size above the maximum saturates.
    send_cmd(CMD_RESIZE, 12'd0, 11'd2047);
    repeat (3) send_cmd(CMD_NEXT, 12'd0, 11'd0);
    // Shrinking below the fill leaves the ring full at the new size.
    send_cmd(CMD_RESIZE, 12'd0, 11'd2);
    send_cmd(CMD_NEXT, 12'd0, 11'd0);
    send_cmd(CMD_INDEX, 12'd1, 11'd0);
    send_cmd(CMD_INDEX, 12'd3, 11'd0);
    send_cmd(CMD_INDEX, 12'd4, 11'd0);
    send_cmd(CMD_ROLLBACK, 12'd1, 11'd0);
    send_cmd(CMD_RESIZE, 12'd0, 11'd1);
    send_cmd(CMD_NEXT, 12'd0, 11'd0);
    send_cmd(CMD_RESET, 12'd0, 11'd0);
    send_cmd(CMD_RESIZE, 12'd0, 11'(MAX_SLOTS));
    for (int u = CMD_FIRST_UNUSED; u < 8; u++) send_cmd(3'(u), 12'd4095, 11'd1024);
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_cmd();
  endtask

  task automatic test_steady_stream(int n);
    steady = 1'b1;
    repeat (n) send_random_cmd();
    steady = 1'b0;
  endtask

  // The receiver holds off while commands keep coming, so the block fills and stalls its input.
  task automatic test_output_backpressure(int n);
    hold_left = 100;
    steady    = 1'b1;
    repeat (n) send_random_cmd();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_sender_pause(int rounds, int n);
    repeat (rounds) begin
      repeat (n) send_random_cmd();
      wait_drained();
    end
  endtask

  initial begin
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    rst_n          = 1'b0;
    steady         = 1'b0;
    hold_left      = 0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    empty_ring();
    ring_size = MAX_SLOTS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic(500);
    test_steady_stream(200);
    test_output_backpressure(60);
    test_sender_pause(4, 40);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: ring_slot_index_manager_core.f
hw/rtl/rsim_pkg.sv
hw/rtl/rsim_ptr_unit.sv
hw/rtl/ring_slot_index_manager_core.sv
tb/sv/tb.sv
